/* rtl/two_level_vq_block_decoder_macros.svh */
`ifndef TWO_LEVEL_VQ_BLOCK_DECODER_MACROS_SVH
`define TWO_LEVEL_VQ_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TLVQD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvqd: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TLVQD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvqd: next-cycle check failed");

`endif

/* rtl/tlvqd_pkg.sv */
package tlvqd_pkg;

    localparam int PIX_W       = 16;
    localparam int POS_W       = 10;
    localparam int BLK_W       = POS_W - 2;
    localparam int CODE_W      = 10;
    localparam int DIM_W       = 11;
    localparam int CFG_INDEX_W = 2;

    localparam int SMALL_ENTRIES = 1024;
    localparam int LARGE_ENTRIES = 1024;
    localparam int SMALL_IDX_W   = $clog2(SMALL_ENTRIES);
    localparam int LARGE_IDX_W   = $clog2(LARGE_ENTRIES);
    localparam int SMALL_ADDR_W  = SMALL_IDX_W + 2;
    localparam int LARGE_ADDR_W  = LARGE_IDX_W + 2;
    localparam int SMALL_DEPTH   = SMALL_ENTRIES * 4;
    localparam int LARGE_DEPTH   = LARGE_ENTRIES * 4;

    localparam logic [DIM_W-1:0] MIN_DIM      = 11'd4;
    localparam logic [DIM_W-1:0] MAX_DIM      = 11'd1024;
    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd240;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [3:0] PIX_LAST = 4'd15;

    typedef enum logic [1:0] {
        CMD_WRITE_SMALL = 2'd0,
        CMD_WRITE_LARGE = 2'd1,
        CMD_DECODE      = 2'd2,
        CMD_RAW         = 2'd3
    } tlvqd_cmd_t;

    typedef struct packed {
        tlvqd_cmd_t        command;
        logic [CODE_W-1:0] code_index;
        logic [1:0]        word_slot;
        logic [PIX_W-1:0]  word_value;
    } tlvqd_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } tlvqd_geom_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < MIN_DIM)
        begin
            r = MIN_DIM;
        end
        else if (v > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

/* rtl/tlvqd_ifs.sv */
interface tlvqd_item_if import tlvqd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [CODE_W-1:0] code_index;
    logic [1:0]        word_slot;
    logic [PIX_W-1:0]  word_value;

    modport source (output valid, output command, output code_index,
                    output word_slot, output word_value, input ready);
    modport sink   (input valid, input command, input code_index,
                    input word_slot, input word_value, output ready);
endinterface

interface tlvqd_result_if import tlvqd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last_of_item;
    logic             last_of_frame;

    modport source (output valid, output pixel, output pos_x, output pos_y,
                    output last_of_item, output last_of_frame, input ready);
    modport sink   (input valid, input pixel, input pos_x, input pos_y,
                    input last_of_item, input last_of_frame, output ready);
endinterface

/* rtl/two_level_vq_block_decoder.sv */
// Two-level vector-quantization block decoder.
// Items arrive on the items channel (valid/ready); a transfer takes place on a
// clock edge with both high. Codebook write commands produce no result. A
// decode command produces the sixteen pixels of one 4x4 block, row by row,
// and a raw command produces one pixel; each pixel leaves on the results
// channel with its frame coordinates and end-of-item and end-of-frame flags.
// Frame size is set through the plain write port (cfg_write_en, cfg_index,
// cfg_data); sizes are clamped to 4..1024 on write. The user must write it
// only while the block is idle; the block itself does not enforce this.
// An item's first pixel is valid once it has passed the queue and the large
// and small codebook registers. The results channel carries one pixel per
// cycle while ready is high; a decode item holds the back end for sixteen
// pixels and a raw or write item for one step. A four-entry queue keeps
// accepting items while the back end works or waits. Once a pixel waits in
// the output register and the receiver holds ready low, the whole back end
// freezes and the queue fills; nothing is dropped. Reset clears the queue,
// the pipeline and the block and raw positions, and sets the frame to 320x240.
// Codebook contents are not cleared and must be written before they are used.
module two_level_vq_block_decoder import tlvqd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    tlvqd_item_if.sink             items,
    tlvqd_result_if.source         results,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    tlvqd_geom_t geom_reg, geom_next;
    logic        item_valid;
    tlvqd_item_t item;
    logic        item_pop;

    always_comb
    begin
        geom_next = geom_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  geom_next.width  = clamp_dim(cfg_data);
                REG_FRAME_HEIGHT: geom_next.height = clamp_dim(cfg_data);
                default:          geom_next = geom_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.width  <= RESET_WIDTH;
            geom_reg.height <= RESET_HEIGHT;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    tlvqd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    tlvqd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .results    (results)
    );

endmodule

/* rtl/tlvqd_front.sv */
module tlvqd_front import tlvqd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    tlvqd_item_if.sink   items,
    output logic         item_valid,
    output tlvqd_item_t  item,
    input  logic         item_pop
);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    tlvqd_item_t      queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    tlvqd_item_t      incoming;

    assign items.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push        = items.valid && items.ready;
    assign item_valid  = (count_reg != '0);
    assign item        = queue_reg[rd_ptr_reg];

    // The raw command field is recast to the command type as it enters the queue.
    always_comb
    begin
        incoming.command    = tlvqd_cmd_t'(items.command);
        incoming.code_index = items.code_index;
        incoming.word_slot  = items.word_slot;
        incoming.word_value = items.word_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (item_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !item_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && item_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

/* rtl/tlvqd_back.sv */
module tlvqd_back import tlvqd_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  tlvqd_geom_t   geom,
    input  logic          item_valid,
    input  tlvqd_item_t   item,
    output logic          item_pop,
    tlvqd_result_if.source results
);

`include "two_level_vq_block_decoder_macros.svh"

    typedef struct packed {
        logic             is_raw;
        logic [PIX_W-1:0] raw_value;
        logic [1:0]       word;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_item;
        logic             last_frame;
    } tlvqd_meta_t;

    logic [PIX_W-1:0]       small_mem [SMALL_DEPTH];
    logic [SMALL_IDX_W-1:0] large_mem [LARGE_DEPTH];
    logic [SMALL_IDX_W-1:0] large_rd_reg;
    logic [PIX_W-1:0]       small_rd_reg;

    logic adv;
    logic is_dec, is_raw, is_wr_small, is_wr_large;
    logic [3:0] pix_cnt_reg, pix_cnt_next;
    logic [1:0] quad;

    logic [BLK_W-1:0] blk_col_reg, blk_col_next, blk_row_reg, blk_row_next;
    logic [BLK_W-1:0] col_eff, row_eff;
    logic [BLK_W:0]   cols, rows, col_inc, row_inc;
    logic             blk_outside, last_block;

    logic [POS_W-1:0] raw_col_reg, raw_col_next, raw_row_reg, raw_row_next;
    logic [POS_W-1:0] raw_col_eff, raw_row_eff;
    logic [DIM_W-1:0] raw_col_inc, raw_row_inc;
    logic             raw_outside, last_raw;

    tlvqd_meta_t a_meta, b_meta_reg, c_meta_reg;
    logic        b_valid_reg, c_valid_reg;

    // The whole back end moves one step whenever the output register is free or drained.
    assign adv = !c_valid_reg || results.ready;

    assign is_dec      = (item.command == CMD_DECODE);
    assign is_raw      = (item.command == CMD_RAW);
    assign is_wr_small = (item.command == CMD_WRITE_SMALL);
    assign is_wr_large = (item.command == CMD_WRITE_LARGE);

    assign item_pop = item_valid && adv && (!is_dec || pix_cnt_reg == PIX_LAST);
    assign quad     = {pix_cnt_reg[3], pix_cnt_reg[1]};

    // Block grid position; a stale position outside a shrunken grid restarts at the origin.
    assign cols        = geom.width[DIM_W-1:2];
    assign rows        = geom.height[DIM_W-1:2];
    assign blk_outside = ({1'b0, blk_col_reg} >= cols) || ({1'b0, blk_row_reg} >= rows);
    assign col_eff     = blk_outside ? '0 : blk_col_reg;
    assign row_eff     = blk_outside ? '0 : blk_row_reg;
    assign col_inc     = {1'b0, col_eff} + (BLK_W+1)'(1);
    assign row_inc     = {1'b0, row_eff} + (BLK_W+1)'(1);
    assign last_block  = ({1'b0, col_eff} == cols - (BLK_W+1)'(1))
                      && ({1'b0, row_eff} == rows - (BLK_W+1)'(1));

    assign raw_outside = ({1'b0, raw_col_reg} >= geom.width)
                      || ({1'b0, raw_row_reg} >= geom.height);
    assign raw_col_eff = raw_outside ? '0 : raw_col_reg;
    assign raw_row_eff = raw_outside ? '0 : raw_row_reg;
    assign raw_col_inc = {1'b0, raw_col_eff} + DIM_W'(1);
    assign raw_row_inc = {1'b0, raw_row_eff} + DIM_W'(1);
    assign last_raw    = ({1'b0, raw_col_eff} == geom.width - DIM_W'(1))
                      && ({1'b0, raw_row_eff} == geom.height - DIM_W'(1));

    always_comb
    begin
        pix_cnt_next = pix_cnt_reg;
        blk_col_next = blk_col_reg;
        blk_row_next = blk_row_reg;
        raw_col_next = raw_col_reg;
        raw_row_next = raw_row_reg;
        if (adv && item_valid && is_dec)
        begin
            pix_cnt_next = pix_cnt_reg + 4'd1;
            if (pix_cnt_reg == PIX_LAST)
            begin
                if (col_inc >= cols)
                begin
                    blk_col_next = '0;
                    blk_row_next = (row_inc >= rows) ? '0 : row_inc[BLK_W-1:0];
                end
                else
                begin
                    blk_col_next = col_inc[BLK_W-1:0];
                    blk_row_next = row_eff;
                end
            end
        end
        if (adv && item_valid && is_raw)
        begin
            if (raw_col_inc >= geom.width)
            begin
                raw_col_next = '0;
                raw_row_next = (raw_row_inc >= geom.height) ? '0 : raw_row_inc[POS_W-1:0];
            end
            else
            begin
                raw_col_next = raw_col_inc[POS_W-1:0];
                raw_row_next = raw_row_eff;
            end
        end
    end

    always_comb
    begin
        a_meta.is_raw     = is_raw;
        a_meta.raw_value  = item.word_value;
        a_meta.word       = {pix_cnt_reg[2], pix_cnt_reg[0]};
        a_meta.pos_x      = is_raw ? raw_col_eff : {col_eff, pix_cnt_reg[1:0]};
        a_meta.pos_y      = is_raw ? raw_row_eff : {row_eff, pix_cnt_reg[3:2]};
        a_meta.last_item  = is_raw || (pix_cnt_reg == PIX_LAST);
        a_meta.last_frame = is_raw ? last_raw : ((pix_cnt_reg == PIX_LAST) && last_block);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
            blk_col_reg <= '0;
            blk_row_reg <= '0;
            raw_col_reg <= '0;
            raw_row_reg <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            pix_cnt_reg <= pix_cnt_next;
            blk_col_reg <= blk_col_next;
            blk_row_reg <= blk_row_next;
            raw_col_reg <= raw_col_next;
            raw_row_reg <= raw_row_next;
            if (adv)
            begin
                b_valid_reg <= item_valid && (is_dec || is_raw);
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_meta_reg <= a_meta;
            c_meta_reg <= b_meta_reg;
        end
    end

    // Large codebook: one quadrant lookup per pixel in the first stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            large_rd_reg <= large_mem[{item.code_index[LARGE_IDX_W-1:0], quad}];
            if (item_valid && is_wr_large)
            begin
                large_mem[{item.code_index[LARGE_IDX_W-1:0], item.word_slot}]
                    <= item.word_value[SMALL_IDX_W-1:0];
            end
        end
    end

    // Small codebook: the pixel lookup in the second stage. A write in the same cycle
    // comes from a later item, so the read must see the old contents.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            small_rd_reg <= small_mem[{large_rd_reg, b_meta_reg.word}];
            if (item_valid && is_wr_small)
            begin
                small_mem[{item.code_index[SMALL_IDX_W-1:0], item.word_slot}]
                    <= item.word_value;
            end
        end
    end

    assign results.valid         = c_valid_reg;
    assign results.pixel         = c_meta_reg.is_raw ? c_meta_reg.raw_value : small_rd_reg;
    assign results.pos_x         = c_meta_reg.pos_x;
    assign results.pos_y         = c_meta_reg.pos_y;
    assign results.last_of_item  = c_meta_reg.last_item;
    assign results.last_of_frame = c_meta_reg.last_frame;

    `TLVQD_ASSERT_NOW(a_cnt_only_in_decode, pix_cnt_reg != 4'd0, item_valid && is_dec)
    `TLVQD_ASSERT_NOW(a_frame_end_ends_item, c_valid_reg && c_meta_reg.last_frame, c_meta_reg.last_item)
    `TLVQD_ASSERT_NEXT(a_stall_freezes_seq, !adv, pix_cnt_reg == $past(pix_cnt_reg))

endmodule

/* tb/two_level_vq_block_decoder_checker.sv */
module two_level_vq_block_decoder_checker import tlvqd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    tlvqd_item_if                  items,
    tlvqd_result_if                results,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_of_item;
        logic             last_of_frame;
    } pixel_out_t;

    logic [PIX_W-1:0]       small_book [SMALL_DEPTH];
    logic [SMALL_IDX_W-1:0] large_book [LARGE_DEPTH];
    logic [BLK_W-1:0]       blk_col;
    logic [BLK_W-1:0]       blk_row;
    logic [POS_W-1:0]       raw_col;
    logic [POS_W-1:0]       raw_row;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;

    pixel_out_t pending_pixels [$];
    pixel_out_t got;
    pixel_out_t want;
    int         mismatch_count;
    int         pixel_count;

    function automatic int fit_dim(input logic [DIM_W-1:0] v);
        int d;
        d = int'(v);
        if (d < int'(MIN_DIM))
        begin
            d = int'(MIN_DIM);
        end
        else if (d > int'(MAX_DIM))
        begin
            d = int'(MAX_DIM);
        end
        return d;
    endfunction

    // Updates the codebooks and positions for one item and queues the pixels it yields.
    task automatic predict_pixels(input tlvqd_cmd_t cmd, input logic [CODE_W-1:0] idx,
                                  input logic [1:0] slot, input logic [PIX_W-1:0] val);
        int         w;
        int         h;
        int         cols;
        int         rows;
        int         col;
        int         row;
        int         entry;
        int         sub;
        int         dy;
        int         dx;
        bit         corner;
        pixel_out_t p;
        w = fit_dim(width_reg);
        h = fit_dim(height_reg);
        case (cmd)
            CMD_WRITE_SMALL:
            begin
                small_book[(int'(idx) % SMALL_ENTRIES) * 4 + int'(slot)] = val;
            end
            CMD_WRITE_LARGE:
            begin
                large_book[(int'(idx) % LARGE_ENTRIES) * 4 + int'(slot)] =
                    SMALL_IDX_W'(int'(val) % SMALL_ENTRIES);
            end
            CMD_DECODE:
            begin
                cols = w >> 2;
                rows = h >> 2;
                col = int'(blk_col);
                row = int'(blk_row);
                // A position left outside a shrunken grid starts over at the top left.
                if (col >= cols || row >= rows)
                begin
                    col = 0;
                    row = 0;
                end
                corner = (col == cols - 1) && (row == rows - 1);
                entry = int'(idx) % LARGE_ENTRIES;
                for (dy = 0; dy < 4; dy++)
                begin
                    for (dx = 0; dx < 4; dx++)
                    begin
                        sub = int'(large_book[entry * 4 + (dy / 2) * 2 + dx / 2]) % SMALL_ENTRIES;
                        p.pixel = small_book[sub * 4 + (dy % 2) * 2 + dx % 2];
                        p.pos_x = POS_W'(col * 4 + dx);
                        p.pos_y = POS_W'(row * 4 + dy);
                        p.last_of_item = (dy == 3) && (dx == 3);
                        p.last_of_frame = p.last_of_item && corner;
                        pending_pixels.push_back(p);
                    end
                end
                col++;
                if (col >= cols)
                begin
                    col = 0;
                    row++;
                    if (row >= rows)
                    begin
                        row = 0;
                    end
                end
                blk_col = BLK_W'(col);
                blk_row = BLK_W'(row);
            end
            CMD_RAW:
            begin
                col = int'(raw_col);
                row = int'(raw_row);
                if (col >= w || row >= h)
                begin
                    col = 0;
                    row = 0;
                end
                p.pixel = val;
                p.pos_x = POS_W'(col);
                p.pos_y = POS_W'(row);
                p.last_of_item = 1'b1;
                p.last_of_frame = (col == w - 1) && (row == h - 1);
                pending_pixels.push_back(p);
                col++;
                if (col >= w)
                begin
                    col = 0;
                    row++;
                    if (row >= h)
                    begin
                        row = 0;
                    end
                end
                raw_col = POS_W'(col);
                raw_row = POS_W'(row);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_col = '0;
            blk_row = '0;
            raw_col = '0;
            raw_row = '0;
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            pending_pixels.delete();
            mismatch_count = 0;
            pixel_count = 0;
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            // Results are checked before this edge's item is predicted, since a
            // result can never come from an item accepted at the same edge.
            if (results.valid && results.ready)
            begin
                got.pixel = results.pixel;
                got.pos_x = results.pos_x;
                got.pos_y = results.pos_y;
                got.last_of_item = results.last_of_item;
                got.last_of_frame = results.last_of_frame;
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected pixel %h at (%0d,%0d) item %b frame %b",
                                 got.pixel, got.pos_x, got.pos_y,
                                 got.last_of_item, got.last_of_frame);
                    end
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixel_count++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("pixel mismatch: expected %h (%0d,%0d) item %b frame %b",
                                     want.pixel, want.pos_x, want.pos_y,
                                     want.last_of_item, want.last_of_frame);
                            $display("                got      %h (%0d,%0d) item %b frame %b",
                                     got.pixel, got.pos_x, got.pos_y,
                                     got.last_of_item, got.last_of_frame);
                        end
                    end
                end
            end
            if (items.valid && items.ready)
            begin
                predict_pixels(tlvqd_cmd_t'(items.command), items.code_index,
                               items.word_slot, items.word_value);
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_data;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            mismatches <= mismatch_count;
            outstanding <= pending_pixels.size();
            checked <= pixel_count;
        end
    end

endmodule

/* tb/two_level_vq_block_decoder_test.sv */
module two_level_vq_block_decoder_test;
    import tlvqd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 7;
    localparam int DECODE_PCT    = 35;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    int mismatches;
    int outstanding;
    int checked;
    int send_idle_pct = 7;
    int recv_idle_pct = 58;
    int stall_cycles  = 0;
    int decodes_sent  = 0;
    int raws_sent     = 0;
    int words_sent    = 0;

    // Which words of each codebook entry have been written, and the entries
    // that are complete and may therefore be read by a decode.
    logic [3:0] small_words [SMALL_ENTRIES];
    logic [3:0] large_words [LARGE_ENTRIES];
    int         full_small [$];
    int         full_large [$];

    // Frame sizes include out-of-range values that the block must clamp.
    int phase_width   [PHASES] = '{4, 1024, 0, 2047, 13, 8, 320};
    int phase_height  [PHASES] = '{4, 1024, 2047, 3, 9, 8, 240};
    int phase_items   [PHASES] = '{30, 30, 25, 25, 40, 30, 30};
    int phase_raw_pct [PHASES] = '{50, 20, 25, 25, 40, 40, 20};

    tlvqd_item_if   items ();
    tlvqd_result_if results ();

    two_level_vq_block_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .results      (results),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    two_level_vq_block_decoder_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .results      (results),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL two_level_vq_block_decoder");
            $finish;
        end
    end

    task automatic send_item(input tlvqd_cmd_t cmd, input int idx, input int slot,
                             input int val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.command <= cmd;
        items.code_index <= CODE_W'(idx);
        items.word_slot <= 2'(slot);
        items.word_value <= PIX_W'(val);
        @(posedge clk);
        while (!items.ready)
        begin
            @(posedge clk);
        end
        case (cmd)
            CMD_WRITE_SMALL:
            begin
                words_sent++;
                if (!small_words[idx][slot])
                begin
                    small_words[idx][slot] = 1'b1;
                    if (small_words[idx] == 4'hF)
                    begin
                        full_small.push_back(idx);
                    end
                end
            end
            CMD_WRITE_LARGE:
            begin
                words_sent++;
                if (!large_words[idx][slot])
                begin
                    large_words[idx][slot] = 1'b1;
                    if (large_words[idx] == 4'hF)
                    begin
                        full_large.push_back(idx);
                    end
                end
            end
            CMD_DECODE:
            begin
                decodes_sent++;
            end
            default:
            begin
                raws_sent++;
            end
        endcase
    endtask

    // Holds the sender off until every predicted pixel has been transferred.
    task automatic drain_pixels();
        items.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int p;
        int n;
        int k;
        int r;
        int e;
        int start;
        bit paused;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        items.valid <= 1'b0;
        items.command <= CMD_WRITE_SMALL;
        items.code_index <= '0;
        items.word_slot <= '0;
        items.word_value <= '0;
        for (e = 0; e < SMALL_ENTRIES; e++)
        begin
            small_words[e] = 4'h0;
        end
        for (e = 0; e < LARGE_ENTRIES; e++)
        begin
            large_words[e] = 4'h0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset frame size: extreme entries, extreme
        // values, small indices that wrap modulo the codebook size.
        send_item(CMD_WRITE_SMALL, 0, 0, 16'h0000);
        send_item(CMD_WRITE_SMALL, 0, 1, 16'hFFFF);
        send_item(CMD_WRITE_SMALL, 0, 2, 16'h5555);
        send_item(CMD_WRITE_SMALL, 0, 3, 16'hAAAA);
        send_item(CMD_WRITE_SMALL, 1023, 3, 16'h1234);
        send_item(CMD_WRITE_SMALL, 1023, 2, 16'hFFFF);
        send_item(CMD_WRITE_SMALL, 1023, 1, 16'h0000);
        send_item(CMD_WRITE_SMALL, 1023, 0, 16'h8001);
        send_item(CMD_WRITE_LARGE, 0, 0, 16'hFFFF);
        send_item(CMD_WRITE_LARGE, 0, 1, 0);
        send_item(CMD_WRITE_LARGE, 0, 2, 1023);
        send_item(CMD_WRITE_LARGE, 0, 3, 16'h0400);
        send_item(CMD_WRITE_LARGE, 1023, 0, 0);
        send_item(CMD_WRITE_LARGE, 1023, 1, 1023);
        send_item(CMD_WRITE_LARGE, 1023, 2, 16'hFC00);
        send_item(CMD_WRITE_LARGE, 1023, 3, 1023);
        send_item(CMD_DECODE, 0, 0, 0);
        send_item(CMD_DECODE, 1023, 3, 16'hFFFF);
        send_item(CMD_RAW, 1023, 3, 16'h0000);
        send_item(CMD_RAW, 0, 0, 16'hFFFF);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct <= 7;
            end
            else if (p == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            // Write items leave no result, so allow the block to finish them.
            drain_pixels();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data <= DIM_W'(phase_width[p]);
            @(posedge clk);
            cfg_index <= REG_FRAME_HEIGHT;
            cfg_data <= DIM_W'(phase_height[p]);
            @(posedge clk);
            cfg_index <= (p % 2 == 0) ? REG_SPARE_LOW : REG_SPARE_HIGH;
            cfg_data <= DIM_W'($urandom);
            @(posedge clk);
            cfg_write_en <= 1'b0;

            n = 0;
            paused = 1'b0;
            while (n < phase_items[p])
            begin
                if (!paused && n >= phase_items[p] / 2)
                begin
                    drain_pixels();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                if (r < phase_raw_pct[p])
                begin
                    send_item(CMD_RAW, $urandom_range(1023), $urandom_range(3),
                              $urandom_range(65535));
                    n++;
                end
                else if (r < phase_raw_pct[p] + DECODE_PCT)
                begin
                    send_item(CMD_DECODE, full_large[$urandom_range(full_large.size() - 1)],
                              $urandom_range(3), $urandom_range(65535));
                    n++;
                end
                else if (r < 90)
                begin
                    // A whole entry, its words in a rotated slot order.
                    e = $urandom_range(1023);
                    start = $urandom_range(3);
                    for (k = 0; k < 4; k++)
                    begin
                        if (r % 2 == 0)
                        begin
                            send_item(CMD_WRITE_SMALL, e, (start + k) % 4, $urandom_range(65535));
                        end
                        else
                        begin
                            send_item(CMD_WRITE_LARGE, e, (start + k) % 4,
                                      full_small[$urandom_range(full_small.size() - 1)] +
                                      SMALL_ENTRIES * $urandom_range(63));
                        end
                    end
                    n += 4;
                end
                else
                begin
                    // A lone word; partial small entries are never referenced.
                    if (r % 2 == 0)
                    begin
                        send_item(CMD_WRITE_SMALL, $urandom_range(1023), $urandom_range(3),
                                  $urandom_range(65535));
                    end
                    else
                    begin
                        send_item(CMD_WRITE_LARGE, $urandom_range(1023), $urandom_range(3),
                                  full_small[$urandom_range(full_small.size() - 1)] +
                                  SMALL_ENTRIES * $urandom_range(63));
                    end
                    n++;
                end
            end
        end

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d decodes, %0d raw pixels and %0d codebook words over %0d frame sizes.",
                 decodes_sent, raws_sent, words_sent, PHASES + 1);
        $display("Compared %0d pixels with the prediction; %0d mismatches.", checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("PASS two_level_vq_block_decoder");
        end
        else
        begin
            $display("FAIL two_level_vq_block_decoder");
        end
        $finish;
    end

endmodule
